// File: rtl/dfgr_pkg.sv
// Shared types, codes and constants for the drop FIFO with gap report unit.
package dfgr_pkg;

  // Default number of ring entries built into the store.
  localparam int MaxDepthDefault = 16;

  // Field widths of the channels.
  localparam int RefW      = 16;
  localparam int BytesW    = 16;
  localparam int CapW      = 16;
  localparam int StatusW   = 3;
  localparam int LostW     = 64;
  localparam int TotalW    = 32;
  localparam int DepthCfgW = 5;
  localparam int GapCfgW   = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_DEPTH_IN_USE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAP_RECORD_BYTES = 2'd1;

  // Configuration reset values.
  localparam logic [DepthCfgW-1:0] DepthResetVal = 5'd16;
  localparam logic [GapCfgW-1:0]   GapResetVal   = 8'd64;

  // Item opcodes.
  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_FETCH   = 1'b1;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_ENQUEUED = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_EVENT    = 3'd2,
    ST_GAP      = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_SMALL    = 3'd5
  } status_e;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_e;

  // One input item.
  typedef struct packed {
    logic              mode;
    logic [RefW-1:0]   event_ref;
    logic [BytesW-1:0] event_bytes;
    logic [CapW-1:0]   buffer_capacity;
  } item_t;

  // One ring entry.
  typedef struct packed {
    logic [BytesW-1:0] bytes;
    logic [RefW-1:0]   handle;
  } entry_t;

  // One result item.
  typedef struct packed {
    status_e           status;
    logic [RefW-1:0]   out_ref;
    logic [BytesW-1:0] out_bytes;
    logic [LostW-1:0]  lost_total;
    logic [TotalW-1:0] delivered_total;
    logic [TotalW-1:0] dropped_total;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

// File: rtl/dfgr_if.sv
// Channel interfaces for items, results and configuration writes.
interface dfgr_in_if;
  import dfgr_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [RefW-1:0]   event_ref;
  logic [BytesW-1:0] event_bytes;
  logic [CapW-1:0]   buffer_capacity;

  modport source (output valid, mode, event_ref, event_bytes, buffer_capacity, input ready);
  modport sink   (input valid, mode, event_ref, event_bytes, buffer_capacity, output ready);
endinterface

interface dfgr_out_if;
  import dfgr_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [RefW-1:0]    out_ref;
  logic [BytesW-1:0]  out_bytes;
  logic [LostW-1:0]   lost_total;
  logic [TotalW-1:0]  delivered_total;
  logic [TotalW-1:0]  dropped_total;

  modport source (output valid, status, out_ref, out_bytes, lost_total, delivered_total,
                  dropped_total, input ready);
  modport sink   (input valid, status, out_ref, out_bytes, lost_total, delivered_total,
                  dropped_total, output ready);
endinterface

interface dfgr_cfg_if;
  import dfgr_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/dfgr_ctrl.sv
// Controller state machine that sequences item capture, execution and result handoff.
module dfgr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output dfgr_pkg::cmd_t cmd_o
);
  import dfgr_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  // In the idle state, an item may enter once the result register is free or being emptied.
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_ready_o && in_valid_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = accept;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // The result register is full from execution until the sink takes the item.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_EXEC) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/dfgr_datapath.sv
// Datapath with the ring store, pointers, counters, configuration and result register.
module dfgr_datapath #(
  parameter int MAX_DEPTH = dfgr_pkg::MaxDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dfgr_pkg::cmd_t    cmd_i,
  input  dfgr_pkg::item_t   item_i,
  dfgr_cfg_if.sink          cfg_i,
  output dfgr_pkg::result_t res_o
);
  import dfgr_pkg::*;

  localparam int IdxW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CntW = $clog2(MAX_DEPTH + 1);

  item_t               item_q;
  entry_t              rd_q;
  entry_t              mem [MAX_DEPTH];
  logic [IdxW-1:0]     head_q, head_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic [LostW-1:0]    lost_q, lost_d;
  logic [TotalW-1:0]   deliv_q, deliv_d;
  logic [TotalW-1:0]   drop_q, drop_d;
  logic [DepthCfgW-1:0] depth_q;
  logic [GapCfgW-1:0]  gap_q;
  result_t             res_q, res_d;

  logic [CntW-1:0]     depth_act;
  logic [CntW:0]       tail_sum;
  logic [CntW:0]       tail_wrap;
  logic [CntW:0]       head_inc;
  logic                wr_en;
  logic                cfg_wr;

  // Configuration writes are taken in every cycle that does not execute an item.
  assign cfg_i.ready = !cmd_i.exec;
  assign cfg_wr      = cfg_i.valid;

  // Depth in use, clamped to the range the store supports.
  always_comb begin
    if (depth_q == '0) begin
      depth_act = CntW'(1);
    end else if (32'(depth_q) > 32'(MAX_DEPTH)) begin
      depth_act = CntW'(MAX_DEPTH);
    end else begin
      depth_act = CntW'(depth_q);
    end
  end

  // Tail slot and next head, wrapped by compare.
  always_comb begin
    tail_sum  = (CntW+1)'(head_q) + (CntW+1)'(fill_q);
    tail_wrap = tail_sum;
    if (tail_sum >= (CntW+1)'(depth_act)) begin
      tail_wrap = tail_sum - (CntW+1)'(depth_act);
    end
    head_inc = (CntW+1)'(head_q) + (CntW+1)'(1);
    if (head_inc >= (CntW+1)'(depth_act)) begin
      head_inc = '0;
    end
  end

  // Execution of the captured item.
  always_comb begin
    head_d  = head_q;
    fill_d  = fill_q;
    lost_d  = lost_q;
    deliv_d = deliv_q;
    drop_d  = drop_q;
    wr_en   = 1'b0;
    res_d   = '0;
    if (item_q.mode == MODE_ENQUEUE) begin
      if (fill_q >= depth_act) begin
        drop_d = drop_q + TotalW'(1);
        if (lost_q != '1) begin
          lost_d = lost_q + LostW'(1);
        end
        res_d.status = ST_DROPPED;
      end else begin
        wr_en        = 1'b1;
        fill_d       = fill_q + CntW'(1);
        deliv_d      = deliv_q + TotalW'(1);
        res_d.status = ST_ENQUEUED;
      end
    end else if (lost_q != '0) begin
      if (item_q.buffer_capacity < CapW'(gap_q)) begin
        res_d.status = ST_SMALL;
      end else begin
        res_d.lost_total = lost_q;
        lost_d           = '0;
        res_d.status     = ST_GAP;
      end
    end else if (fill_q == '0) begin
      res_d.status = ST_EMPTY;
    end else if (item_q.buffer_capacity < rd_q.bytes) begin
      res_d.status = ST_SMALL;
    end else begin
      res_d.out_ref   = rd_q.handle;
      res_d.out_bytes = rd_q.bytes;
      head_d          = head_inc[IdxW-1:0];
      fill_d          = fill_q - CntW'(1);
      res_d.status    = ST_EVENT;
    end
    res_d.delivered_total = deliv_d;
    res_d.dropped_total   = drop_d;
  end

  // Ring store: one write port at the tail, registered read at the head.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[tail_wrap[IdxW-1:0]] <= '{bytes: item_q.event_bytes, handle: item_q.event_ref};
    end
    rd_q <= mem[head_q];
  end

  // Captured item and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  // Queue state, counters and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      fill_q  <= '0;
      lost_q  <= '0;
      deliv_q <= '0;
      drop_q  <= '0;
      depth_q <= DepthResetVal;
      gap_q   <= GapResetVal;
    end else begin
      if (cmd_i.exec) begin
        head_q  <= head_d;
        fill_q  <= fill_d;
        lost_q  <= lost_d;
        deliv_q <= deliv_d;
        drop_q  <= drop_d;
      end else if (cfg_wr) begin
        case (cfg_i.index)
          CFG_DEPTH_IN_USE: begin
            depth_q <= cfg_i.data[DepthCfgW-1:0];
            head_q  <= '0;
            fill_q  <= '0;
          end
          CFG_GAP_RECORD_BYTES: begin
            gap_q <= cfg_i.data[GapCfgW-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/drop_fifo_with_gap_report_unit.sv
// Top level of the drop FIFO with gap report unit.
// A per-client event ring of up to MAX_DEPTH entries, depth_in_use of which are used.
// An enqueue item stores an event handle and length, or counts a drop when the ring is
// full; a fetch item reports a pending gap with the lost count first, then pops the head
// event, or reports empty or a buffer that is too small. Each item is first captured
// while the ring store's registered read port fetches the head entry, and then executed
// to load the result register; the next item enters as the result is taken. Writing
// depth_in_use empties the ring; the lost count and totals are kept.
module drop_fifo_with_gap_report_unit #(
  parameter int MAX_DEPTH = dfgr_pkg::MaxDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dfgr_in_if.sink     in_i,
  dfgr_out_if.source  out_o,
  dfgr_cfg_if.sink    cfg_i
);
  import dfgr_pkg::*;

  cmd_t    cmd;
  item_t   item;
  result_t res;
  logic    in_ready;
  logic    out_valid;

  // Pack the incoming item.
  assign item.mode            = in_i.mode;
  assign item.event_ref       = in_i.event_ref;
  assign item.event_bytes     = in_i.event_bytes;
  assign item.buffer_capacity = in_i.buffer_capacity;
  assign in_i.ready           = in_ready;

  dfgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  dfgr_datapath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .item_i (item),
    .cfg_i  (cfg_i),
    .res_o  (res)
  );

  // Unpack the result item.
  assign out_o.valid           = out_valid;
  assign out_o.status          = res.status;
  assign out_o.out_ref         = res.out_ref;
  assign out_o.out_bytes       = res.out_bytes;
  assign out_o.lost_total      = res.lost_total;
  assign out_o.delivered_total = res.delivered_total;
  assign out_o.dropped_total   = res.dropped_total;

endmodule
